// ===== sv/ole_pkg.sv =====
// Shared types and constants of the label encoder.
package ole_pkg;

  localparam int WORD_W      = 64;
  localparam int VAL_W       = 63;
  localparam int LEN_W       = 6;
  localparam int CNT_W       = 6;
  localparam int INDEX_W     = 5;
  localparam int TOTAL_W     = 24;
  localparam int WBITS_W     = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_END    = 2'd2
  } op_t;

  // Command passed from the classifier to the packer.
  typedef struct packed {
    logic              is_end;
    logic [WORD_W-1:0] sum;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

// ===== sv/ordpath_label_encoder_unit.sv =====
// Top level of the prefix-code label encoder: config register, front, queue and packer.
// Path: a word-completing encode or an end item passes the input registers, the code RAM
//   read, the command queue and the result register before its result shows (empty low).
// Throughput: one item per cycle while results are drained; full rises once four items
//   sit between the front stages and the command queue.
// Reset (rst, synchronous): clears the packer, the queue and the result register and sets
//   interval_count to 1; the interval table keeps its contents and must be loaded.
module ordpath_label_encoder_unit #(
  parameter int MAX_INTERVALS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   op,
  input  logic [ole_pkg::INDEX_W-1:0]  entry_index,
  input  logic [ole_pkg::VAL_W-1:0]    entry_lower_bound,
  input  logic [ole_pkg::WORD_W-1:0]   entry_bias,
  input  logic [ole_pkg::LEN_W-1:0]    entry_code_length,
  input  logic [ole_pkg::VAL_W-1:0]    component,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [ole_pkg::CNT_W-1:0]    cfg_wr_data,
  // result channel
  output logic                         empty,
  input  logic                         pop,
  output logic [ole_pkg::WORD_W-1:0]   out_word,
  output logic [ole_pkg::WBITS_W-1:0]  word_bits,
  output logic                         label_done,
  output logic [ole_pkg::TOTAL_W-1:0]  total_bits
);

  logic [ole_pkg::CNT_W-1:0]  interval_count;
  logic                       q_push;
  ole_pkg::cmd_t              q_in;
  ole_pkg::cmd_t              q_out;
  logic                       q_valid;
  logic                       q_pop;
  logic [ole_pkg::QCNT_W-1:0] q_count;
  logic                       out_valid;

  // Hold the interval count; the user must write it only while idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_count <= ole_pkg::CNT_W'(1);
    end else if (cfg_wr_en) begin
      interval_count <= cfg_wr_data;
    end
  end

  // Front: transfer items in, pick the interval, read bias and length, form the code sum.
  ole_front #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .op                (op),
    .entry_index       (entry_index),
    .entry_lower_bound (entry_lower_bound),
    .entry_bias        (entry_bias),
    .entry_code_length (entry_code_length),
    .component         (component),
    .interval_count    (interval_count),
    .q_count           (q_count),
    .q_push            (q_push),
    .q_item            (q_in)
  );

  // Decouple the two halves so the packer can stall on the consumer alone.
  ole_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (q_in),
    .pop      (q_pop),
    .item_out (q_out),
    .valid    (q_valid),
    .count    (q_count)
  );

  // Back: append codes, emit full words and end-of-label words.
  ole_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_out),
    .q_pop      (q_pop),
    .out_pop    (pop && out_valid),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .word_bits  (word_bits),
    .label_done (label_done),
    .total_bits (total_bits)
  );

  assign empty = !out_valid;

  // The credit check must keep the queue from overflowing.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= ole_pkg::QCNT_W'(ole_pkg::QUEUE_DEPTH))
    else $error("command queue over capacity");

  // A mid-label word is always complete and carries no total.
  a_mid_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && !label_done) |-> ((word_bits == 7'd64) && (total_bits == '0)))
    else $error("partial word emitted before end of label");

  // Reset leaves nothing waiting on either side.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (empty && (q_count == '0)))
    else $error("state left after reset");

endmodule

// ===== sv/ole_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ole_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ole_front.sv =====
// Front end: accepts items, picks the interval and forms the biased code value.
module ole_front #(
  parameter int MAX_INTERVALS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   op,
  input  logic [ole_pkg::INDEX_W-1:0]  entry_index,
  input  logic [ole_pkg::VAL_W-1:0]    entry_lower_bound,
  input  logic [ole_pkg::WORD_W-1:0]   entry_bias,
  input  logic [ole_pkg::LEN_W-1:0]    entry_code_length,
  input  logic [ole_pkg::VAL_W-1:0]    component,
  input  logic [ole_pkg::CNT_W-1:0]    interval_count,
  input  logic [ole_pkg::QCNT_W-1:0]   q_count,
  output logic                         q_push,
  output ole_pkg::cmd_t                q_item
);

  localparam int IdxW = $clog2(MAX_INTERVALS);
  localparam int RamW = ole_pkg::WORD_W + ole_pkg::LEN_W;

  ole_pkg::op_t               in_kind;
  logic                       accept;
  logic                       load_ok;
  logic                       keep;
  logic [IdxW-1:0]            sel_idx;
  logic [ole_pkg::QCNT_W-1:0] in_flight;

  logic [ole_pkg::VAL_W-1:0]  bound [MAX_INTERVALS];

  logic                       s1_valid;
  ole_pkg::op_t               s1_kind;
  logic [IdxW-1:0]            s1_sel;
  logic [IdxW-1:0]            s1_idx;
  logic [ole_pkg::VAL_W-1:0]  s1_comp;
  logic [ole_pkg::WORD_W-1:0] s1_bias;
  logic [ole_pkg::LEN_W-1:0]  s1_len;

  logic                       s2_valid;
  logic                       s2_end;
  logic [ole_pkg::VAL_W-1:0]  s2_comp;

  logic [RamW-1:0]            rd_data;
  logic [ole_pkg::WORD_W-1:0] rd_bias;
  logic [ole_pkg::LEN_W-1:0]  rd_len;

  // Reserve a queue slot for every item still in the front stages.
  assign in_flight = ole_pkg::QCNT_W'(s1_valid) + ole_pkg::QCNT_W'(s2_valid) + q_count;
  assign full      = in_flight >= ole_pkg::QCNT_W'(ole_pkg::QUEUE_DEPTH);
  assign accept    = push && !full;
  assign in_kind   = ole_pkg::op_t'(op);
  assign load_ok   = int'(entry_index) < MAX_INTERVALS;

  always_comb begin
    unique case (in_kind)
      ole_pkg::OP_LOAD:   keep = accept && load_ok;
      ole_pkg::OP_ENCODE: keep = accept;
      ole_pkg::OP_END:    keep = accept;
      default:            keep = 1'b0;
    endcase
  end

  // Highest entry below the count whose bound is at most the component.
  // A count of zero or above the table size needs no clamp here.
  always_comb begin
    sel_idx = '0;
    for (int i = 1; i < MAX_INTERVALS; i++) begin
      if ((i < int'(interval_count)) &&
          ($signed(component) >= $signed(bound[i]))) begin
        sel_idx = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_kind == ole_pkg::OP_LOAD) && load_ok) begin
      bound[IdxW'(entry_index)] <= entry_lower_bound;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= keep;
      s2_valid <= s1_valid && (s1_kind != ole_pkg::OP_LOAD);
    end
    s1_kind <= in_kind;
    s1_sel  <= sel_idx;
    s1_idx  <= IdxW'(entry_index);
    s1_comp <= component;
    s1_bias <= entry_bias;
    s1_len  <= entry_code_length;
    s2_end  <= s1_kind == ole_pkg::OP_END;
    s2_comp <= s1_comp;
  end

  ole_ram #(
    .WIDTH (RamW),
    .DEPTH (MAX_INTERVALS)
  ) u_code_ram (
    .clk   (clk),
    .we    (s1_valid && (s1_kind == ole_pkg::OP_LOAD)),
    .waddr (s1_idx),
    .wdata ({s1_bias, s1_len}),
    .raddr (s1_sel),
    .rdata (rd_data)
  );

  assign rd_bias = rd_data[RamW-1:ole_pkg::LEN_W];
  assign rd_len  = rd_data[ole_pkg::LEN_W-1:0];

  // Drop encodes of zero length: they append nothing.
  assign q_push        = s2_valid && (s2_end || (rd_len != '0));
  assign q_item.is_end = s2_end;
  assign q_item.sum    = {s2_comp[ole_pkg::VAL_W-1], s2_comp} + rd_bias;
  assign q_item.len    = rd_len;

endmodule

// ===== sv/ole_queue.sv =====
// Short command queue between the classifier and the packer.
module ole_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  ole_pkg::cmd_t              item_in,
  input  logic                       pop,
  output ole_pkg::cmd_t              item_out,
  output logic                       valid,
  output logic [ole_pkg::QCNT_W-1:0] count
);

  ole_pkg::cmd_t              slots [ole_pkg::QUEUE_DEPTH];
  logic [ole_pkg::QPTR_W-1:0] wptr;
  logic [ole_pkg::QPTR_W-1:0] rptr;
  logic                       do_push;
  logic                       do_pop;

  assign valid    = count != '0;
  assign item_out = slots[rptr];
  assign do_pop   = pop && valid;
  assign do_push  = push && (count != ole_pkg::QCNT_W'(ole_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + ole_pkg::QCNT_W'(do_push) - ole_pkg::QCNT_W'(do_pop);
    end
    if (do_push) begin
      slots[wptr] <= item_in;
    end
  end

endmodule

// ===== sv/ole_back.sv =====
// Back end: packs codes into 64-bit words and holds the result register.
module ole_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  ole_pkg::cmd_t               q_item,
  output logic                        q_pop,
  input  logic                        out_pop,
  output logic                        out_valid,
  output logic [ole_pkg::WORD_W-1:0]  out_word,
  output logic [ole_pkg::WBITS_W-1:0] word_bits,
  output logic                        label_done,
  output logic [ole_pkg::TOTAL_W-1:0] total_bits
);

  logic [ole_pkg::WORD_W-1:0]    accumulator;
  logic [ole_pkg::LEN_W-1:0]     fill_count;
  logic [ole_pkg::TOTAL_W-1:0]   bit_total;

  logic [ole_pkg::WORD_W-1:0]    code;
  logic [ole_pkg::WBITS_W-1:0]   fill_sum;
  logic [ole_pkg::WBITS_W-1:0]   shamt;
  logic [2*ole_pkg::WORD_W-1:0]  placed;
  logic [2*ole_pkg::WORD_W-1:0]  merged;
  logic [ole_pkg::TOTAL_W:0]     total_sum;
  logic [ole_pkg::TOTAL_W-1:0]   bit_total_next;

  assign q_pop = q_valid && (!out_valid || out_pop);

  // Place the code so its top bit lands just below the filled bits.
  always_comb begin
    code     = q_item.sum & ~({ole_pkg::WORD_W{1'b1}} << q_item.len);
    fill_sum = ole_pkg::WBITS_W'(fill_count) + ole_pkg::WBITS_W'(q_item.len);
    shamt    = ole_pkg::WBITS_W'(0) - fill_sum;
    placed   = {{ole_pkg::WORD_W{1'b0}}, code} << shamt;
    merged   = {accumulator, {ole_pkg::WORD_W{1'b0}}} | placed;
    total_sum = (ole_pkg::TOTAL_W + 1)'(bit_total) + (ole_pkg::TOTAL_W + 1)'(q_item.len);
    bit_total_next = total_sum[ole_pkg::TOTAL_W] ? ole_pkg::TOTAL_MAX
                                                 : total_sum[ole_pkg::TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      accumulator <= '0;
      fill_count  <= '0;
      bit_total   <= '0;
    end else begin
      if (out_pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        if (q_item.is_end) begin
          out_valid   <= 1'b1;
          out_word    <= accumulator;
          word_bits   <= ole_pkg::WBITS_W'(fill_count);
          label_done  <= 1'b1;
          total_bits  <= bit_total;
          accumulator <= '0;
          fill_count  <= '0;
          bit_total   <= '0;
        end else begin
          bit_total  <= bit_total_next;
          fill_count <= fill_sum[ole_pkg::LEN_W-1:0];
          if (fill_sum[ole_pkg::LEN_W]) begin
            out_valid   <= 1'b1;
            out_word    <= merged[2*ole_pkg::WORD_W-1:ole_pkg::WORD_W];
            word_bits   <= ole_pkg::WBITS_W'(ole_pkg::WORD_W);
            label_done  <= 1'b0;
            total_bits  <= '0;
            accumulator <= merged[ole_pkg::WORD_W-1:0];
          end else begin
            accumulator <= merged[2*ole_pkg::WORD_W-1:ole_pkg::WORD_W];
          end
        end
      end
    end
  end

endmodule

// ===== bench/ordpath_label_encoder_unit_test.sv =====
// Self-checking bench for the label encoder: directed and random labels against a packing model.
module ordpath_label_encoder_unit_test;

  localparam int TABLE_DEPTH   = 32;
  localparam int QUIET_LIMIT   = 2000;  // cycles without any transfer before giving up
  localparam int SETTLE_CYCLES = 8;     // cycles to let items that produce no word drain
  localparam int REPORT_CAP    = 100;   // mismatch lines printed at most
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Component extremes, sign-extended to 64 bits.
  localparam logic [ole_pkg::WORD_W-1:0] VAL_MIN = 64'hC000_0000_0000_0000;
  localparam logic [ole_pkg::WORD_W-1:0] VAL_MAX = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]                  op;
    logic [ole_pkg::INDEX_W-1:0] index;
    logic [ole_pkg::VAL_W-1:0]   bound;
    logic [ole_pkg::WORD_W-1:0]  bias;
    logic [ole_pkg::LEN_W-1:0]   len;
    logic [ole_pkg::VAL_W-1:0]   value;
  } label_item_t;

  typedef struct packed {
    logic [ole_pkg::WORD_W-1:0]  word;
    logic [ole_pkg::WBITS_W-1:0] nbits;
    logic                        done;
    logic [ole_pkg::TOTAL_W-1:0] total;
  } packed_word_t;

  // Ports of the block; every input starts at a known value.
  logic                         clk;
  logic                         rst;
  logic                         push = 1'b0;
  logic                         full;
  logic [1:0]                   op = '0;
  logic [ole_pkg::INDEX_W-1:0]  entry_index = '0;
  logic [ole_pkg::VAL_W-1:0]    entry_lower_bound = '0;
  logic [ole_pkg::WORD_W-1:0]   entry_bias = '0;
  logic [ole_pkg::LEN_W-1:0]    entry_code_length = '0;
  logic [ole_pkg::VAL_W-1:0]    component = '0;
  logic                         cfg_wr_en = 1'b0;
  logic [ole_pkg::CNT_W-1:0]    cfg_wr_data = '0;
  logic                         empty;
  logic                         pop = 1'b0;
  logic [ole_pkg::WORD_W-1:0]   out_word;
  logic [ole_pkg::WBITS_W-1:0]  word_bits;
  logic                         label_done;
  logic [ole_pkg::TOTAL_W-1:0]  total_bits;

  // Items waiting for the driver, and words the packing model expects, oldest first.
  label_item_t  label_items[$];
  packed_word_t pending_words[$];

  // Packing model state: interval table, packer and the interval_count register.
  logic [ole_pkg::WORD_W-1:0]  code_bound [TABLE_DEPTH];
  logic [ole_pkg::WORD_W-1:0]  code_bias  [TABLE_DEPTH];
  logic [ole_pkg::LEN_W-1:0]   code_len   [TABLE_DEPTH];
  logic [ole_pkg::WORD_W-1:0]  pack_acc;
  int                          pack_fill;
  logic [ole_pkg::TOTAL_W-1:0] pack_total;
  logic [ole_pkg::CNT_W-1:0]   interval_count;

  // Bounds of the current well-formed table, used to aim components at intervals.
  logic [ole_pkg::WORD_W-1:0]  gen_bound [TABLE_DEPTH];

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  mismatches     = 0;
  int  quiet_cycles   = 0;
  bit  item_taken     = 1'b0;

  ordpath_label_encoder_unit u_dut (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .op                (op),
    .entry_index       (entry_index),
    .entry_lower_bound (entry_lower_bound),
    .entry_bias        (entry_bias),
    .entry_code_length (entry_code_length),
    .component         (component),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .empty             (empty),
    .pop               (pop),
    .out_word          (out_word),
    .word_bits         (word_bits),
    .label_done        (label_done),
    .total_bits        (total_bits)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [ole_pkg::WORD_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Advance the packing model by one transferred item; queue any word it completes.
  task automatic pack_label_item(input logic [1:0] cmd,
                                 input logic [ole_pkg::INDEX_W-1:0] idx,
                                 input logic [ole_pkg::VAL_W-1:0] bnd,
                                 input logic [ole_pkg::WORD_W-1:0] bias,
                                 input logic [ole_pkg::LEN_W-1:0] len,
                                 input logic [ole_pkg::VAL_W-1:0] value);
    logic [ole_pkg::WORD_W-1:0] v;
    logic [ole_pkg::WORD_W-1:0] code;
    int n;
    int sel;
    int nbits;
    packed_word_t w;
    case (cmd)
      ole_pkg::OP_LOAD: begin
        code_bound[idx] = {bnd[ole_pkg::VAL_W-1], bnd};
        code_bias[idx]  = bias;
        code_len[idx]   = len;
      end
      ole_pkg::OP_ENCODE: begin
        v = {value[ole_pkg::VAL_W-1], value};
        // Clamp the count: zero behaves as one, anything past the table as the table size.
        if (interval_count == 0) n = 1;
        else if (interval_count > TABLE_DEPTH) n = TABLE_DEPTH;
        else n = interval_count;
        // Highest in-use entry whose bound is at most the value; entry 0 catches the rest.
        sel = 0;
        for (int i = 1; i < n; i++)
          if ($signed(v) >= $signed(code_bound[i])) sel = i;
        nbits = code_len[sel];
        if (nbits != 0) begin
          // Keep the low nbits of value+bias, left-aligned, and append behind the fill.
          code = (v + code_bias[sel]) << (ole_pkg::WORD_W - nbits);
          pack_acc |= code >> pack_fill;
          pack_fill += nbits;
          pack_total = (pack_total + nbits > ole_pkg::TOTAL_MAX) ? ole_pkg::TOTAL_MAX
                       : ole_pkg::TOTAL_W'(pack_total + nbits);
          if (pack_fill >= ole_pkg::WORD_W) begin
            w.word  = pack_acc;
            w.nbits = ole_pkg::WBITS_W'(ole_pkg::WORD_W);
            w.done  = 1'b0;
            w.total = '0;
            pending_words.push_back(w);
            pack_fill -= ole_pkg::WORD_W;
            // Carry the code bits that spilled past the full word.
            pack_acc = code << (nbits - pack_fill);
          end
        end
      end
      ole_pkg::OP_END: begin
        w.word  = pack_acc;
        w.nbits = ole_pkg::WBITS_W'(pack_fill);
        w.done  = 1'b1;
        w.total = pack_total;
        pending_words.push_back(w);
        pack_acc   = '0;
        pack_fill  = 0;
        pack_total = '0;
      end
      default: ;  // unused op: nothing happens
    endcase
  endtask

  task automatic check_field(input string name, input logic [ole_pkg::WORD_W-1:0] want,
                             input logic [ole_pkg::WORD_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Monitor: sample both channels at the rising edge, before the block updates them.
  always @(posedge clk) begin : monitor
    packed_word_t w;
    if (rst) begin
      pack_acc       = '0;
      pack_fill      = 0;
      pack_total     = '0;
      interval_count = ole_pkg::CNT_W'(1);
      item_taken     = 1'b0;
      quiet_cycles   = 0;
    end else begin
      // Predict first so a word could never be compared before its item is seen.
      item_taken = push && !full;
      if (item_taken)
        pack_label_item(op, entry_index, entry_lower_bound, entry_bias, entry_code_length,
                        component);
      if (pop && !empty) begin
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("%0t: unexpected result, expected none, actual word %h bits %0d done %0b",
                     $time, out_word, word_bits, label_done);
        end else begin
          w = pending_words.pop_front();
          check_field("out_word", w.word, out_word);
          check_field("word_bits", w.nbits, word_bits);
          check_field("label_done", w.done, label_done);
          check_field("total_bits", w.total, total_bits);
        end
      end
      quiet_cycles = (item_taken || (pop && !empty)) ? 0 : quiet_cycles + 1;
    end
  end

  // Driver: change inputs at the falling edge only.
  always @(negedge clk) begin : driver
    label_item_t it;
    if (rst) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      // Drop the item that transferred at the last rising edge.
      if (item_taken) it = label_items.pop_front();
      // Hold a presented item until it transfers; otherwise maybe idle.
      if (!push || item_taken) begin
        if (label_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          it = label_items[0];
          push              <= 1'b1;
          op                <= it.op;
          entry_index       <= it.index;
          entry_lower_bound <= it.bound;
          entry_bias        <= it.bias;
          entry_code_length <= it.len;
          component         <= it.value;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when nothing transfers for too long.
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no transfer in %0d cycles, %0d items and %0d results outstanding",
             $time, quiet_cycles, label_items.size(), pending_words.size());
    $display("status: fail");
    $finish;
  end

  task automatic queue_item(input logic [1:0] cmd, input int idx,
                            input logic [ole_pkg::WORD_W-1:0] bnd,
                            input logic [ole_pkg::WORD_W-1:0] bias, input int len,
                            input logic [ole_pkg::WORD_W-1:0] value);
    label_item_t it;
    it.op    = cmd;
    it.index = ole_pkg::INDEX_W'(idx);
    it.bound = bnd[ole_pkg::VAL_W-1:0];
    it.bias  = bias;
    it.len   = ole_pkg::LEN_W'(len);
    it.value = value[ole_pkg::VAL_W-1:0];
    label_items.push_back(it);
  endtask

  task automatic queue_load(input int idx, input logic [ole_pkg::WORD_W-1:0] bnd,
                            input logic [ole_pkg::WORD_W-1:0] bias, input int len);
    queue_item(ole_pkg::OP_LOAD, idx, bnd, bias, len, rand64());
  endtask

  // Fields an encode or end does not use carry random junk.
  task automatic queue_encode(input logic [ole_pkg::WORD_W-1:0] value);
    queue_item(ole_pkg::OP_ENCODE, $urandom_range(31), rand64(), rand64(), $urandom_range(63),
               value);
  endtask

  task automatic queue_end();
    queue_item(ole_pkg::OP_END, $urandom_range(31), rand64(), rand64(), $urandom_range(63),
               rand64());
  endtask

  // Wait until every item has transferred and every word has arrived, then let the
  // pipeline empty of items that produce nothing.
  task automatic settle();
    while (label_items.size() != 0 || push || pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_interval_count(input logic [ole_pkg::CNT_W-1:0] cnt);
    settle();
    cfg_wr_data <= cnt;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    interval_count = cnt;
  endtask

  // Aim mostly inside an interval, sometimes at its edge, the extremes or anywhere.
  function automatic logic [ole_pkg::WORD_W-1:0] pick_component(
      input int n, input logic [ole_pkg::WORD_W-1:0] step);
    int j;
    int r;
    j = $urandom_range(n - 1);
    r = $urandom_range(9);
    if (r < 7) return gen_bound[j] + (rand64() & (step - 1));
    if (r == 7) return gen_bound[j] - $urandom_range(1);
    if (r == 8) return $urandom_range(1) ? VAL_MAX : VAL_MIN;
    return rand64();
  endfunction

  // One phase: set the count, load a sorted table over every in-use entry, then labels.
  task automatic run_phase(input logic [ole_pkg::CNT_W-1:0] cnt, input int send_pct,
                           input int stall_pct, input int budget);
    int n;
    int k;
    int m;
    int r;
    int len;
    logic [ole_pkg::WORD_W-1:0] step;
    logic [ole_pkg::WORD_W-1:0] lo;
    write_interval_count(cnt);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    n = (cnt == 0) ? 1 : ((cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt);
    // Intervals of one width, centered on zero, each bound jittered inside its slot.
    k    = $urandom_range(56, 1);
    step = 64'd1 << k;
    lo   = -((step * n) >> 1);
    for (int i = 0; i < n; i++) begin
      gen_bound[i] = lo + step * i + (rand64() & (step - 1));
      len = ($urandom_range(7) == 0) ? $urandom_range(63, 17) : $urandom_range(16, 1);
      queue_load(i, gen_bound[i], rand64(), len);
    end
    while (budget > 0) begin
      r = $urandom_range(99);
      if (r < 78) begin
        // Well-formed label: a run of encodes closed by an end.
        m = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(10, 0);
        for (int i = 0; i < m; i++) queue_encode(pick_component(n, step));
        queue_end();
        budget -= m + 1;
      end else if (r < 88) begin
        // Reload any entry with arbitrary contents; in-use entries stay loaded.
        queue_load($urandom_range(31), rand64(), rand64(), $urandom_range(63, 1));
        budget--;
      end else if (r < 94) begin
        // Stray encode that spills into the next label.
        queue_encode(pick_component(n, step));
        budget--;
      end else if (r < 97) begin
        queue_end();
        budget--;
      end else begin
        queue_item(OP_UNUSED, $urandom_range(31), rand64(), rand64(), $urandom_range(63),
                   rand64());
        budget--;
      end
    end
  endtask

  initial begin : stimulus
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset count of one: only entry 0 is ever consulted.
    queue_load(0, '0, 64'h7FFF_FFFF_FFFF_FFFF, 63);
    queue_encode(VAL_MAX);
    queue_encode(VAL_MIN);
    queue_end();
    queue_end();  // nothing pending
    // Bias of all ones with a one-bit code: the sum is wider than the code.
    queue_load(0, VAL_MAX, '1, 1);
    queue_encode('0);
    queue_item(OP_UNUSED, 5, rand64(), rand64(), 9, rand64());
    queue_end();

    // Four intervals, one of them with zero code length.
    write_interval_count(4);
    queue_load(0, rand64(), 64'h8000_0000_0000_0000, 5);
    queue_load(1, -64'sd100, 64'd1, 0);
    queue_load(2, '0, '0, 20);
    queue_load(3, 64'd1000, '0, 40);
    queue_load(31, VAL_MIN, '0, 63);  // top entry, not in use at this count
    queue_encode(-64'sd101);  // below every other bound: entry 0
    queue_encode(-64'sd100);  // exactly on a bound, zero-length entry
    queue_encode(-64'sd1);
    queue_encode('0);
    queue_encode(64'd999);
    queue_encode(64'd1000);
    queue_encode(VAL_MAX);    // above the range: last interval
    queue_encode(VAL_MIN);
    queue_end();

    // Random phases over counts, the out-of-range ones included, and idle patterns.
    run_phase(6'd32, 0, 0, 165);
    run_phase(6'd63, 51, 0, 165);
    run_phase(6'd0, 0, 51, 165);
    run_phase(6'd7, 15, 15, 165);
    run_phase(6'd1, 51, 0, 165);
    run_phase(6'd20, 0, 51, 165);
    run_phase(6'd32, 15, 15, 165);
    run_phase(6'd2, 0, 0, 155);
    settle();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ole_pkg.sv
sv/ole_ram.sv
sv/ole_front.sv
sv/ole_queue.sv
sv/ole_back.sv
sv/ordpath_label_encoder_unit.sv
bench/ordpath_label_encoder_unit_test.sv
